[rtl/mmwg_pkg.sv]
`default_nettype none

package mmwg_pkg;

  // default parameter values
  localparam int COS_TABLE_BITS_DEF = 10;
  localparam int INDEX_BITS_DEF     = 16;

  // fixed point constants for the cosine table
  localparam longint Q30_ONE             = 64'sd1073741824;
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
  localparam int COS_ENTRY_BITS          = 17;

  // register file
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_WAVE_MODE    = 3'd0,
    REG_AMPLITUDE    = 3'd1,
    REG_PHASE_STEP   = 3'd2,
    REG_PHASE_START  = 3'd3,
    REG_DECAY_FACTOR = 3'd4,
    REG_RAMP_STEP    = 3'd5,
    REG_START_VALUE  = 3'd6,
    REG_SAMPLE_COUNT = 3'd7
  } reg_index_t;

  // waveform selection, low two bits of wave_mode
  typedef enum logic [1:0] {
    MODE_CONST = 2'd0,
    MODE_COS   = 2'd1,
    MODE_EXP   = 2'd2,
    MODE_RAMP  = 2'd3
  } mode_t;

  // register reset values
  localparam logic [2:0]  WAVE_MODE_RST    = 3'd0;
  localparam logic [31:0] AMPLITUDE_RST    = 32'h0001_0000;
  localparam logic [31:0] PHASE_STEP_RST   = 32'd0;
  localparam logic [31:0] PHASE_START_RST  = 32'd0;
  localparam logic [15:0] DECAY_FACTOR_RST = 16'hFFFF;
  localparam logic [31:0] RAMP_STEP_RST    = 32'd0;
  localparam logic [31:0] START_VALUE_RST  = 32'd0;
  localparam logic [15:0] SAMPLE_COUNT_RST = 16'd101;

  // rounding helpers
  localparam logic [33:0] ROUND_HALF = 34'h0_0000_8000;
  localparam logic [33:0] ROUND_MASK = 34'h3_FFFF_0000;
  localparam logic [33:0] ROUND_CAP  = 34'h0_7FFF_0000;

endpackage

`default_nettype wire

[rtl/multi_mode_waveform_generator_top.sv]
// multi-mode waveform generator, one q16.16 sample per input beat
//
// input channel (in_valid/in_ready, payload restart): every beat asks for the
// next sample; restart=1 rewinds the sequence to index 0 first
// output channel (out_valid/out_ready, payload sample, sample_index, last):
// one result beat per input beat, in order; last marks the final sample of a
// sequence, after which the sequence rewinds on its own
// config port: cfg_write loads cfg_data into register cfg_index at the clock
// edge; the user must write only while no beats are in flight, which the
// block does not enforce; phase start and start value reach the sequence
// state at the next restart or wrap, the other registers at once
// throughput: one beat per clock unless the output stalls, set by the state
// update loop (one 32x16 multiply for exponential decay, or a 33-bit
// saturating add for the ramp); three stages: state/fold with the cosine rom
// read, amplitude multiply, output select and rounding into output register
// stalls: each stage holds when the one after it is full, so in_ready stays
// high while bubbles remain and falls only with all three stages occupied
// reset: synchronous; registers return to defaults, the sequence to index 0,
// and all stages empty
`default_nettype none

module multi_mode_waveform_generator_top
  import mmwg_pkg::*;
#(
  parameter int COS_TABLE_BITS = COS_TABLE_BITS_DEF,
  parameter int INDEX_BITS     = INDEX_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // configuration
  input  wire logic                      cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  // input channel
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      restart,
  // output channel
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [31:0]             sample,
  output logic        [15:0]             sample_index,
  output logic                           last
);

  localparam int QTR = 1 << (COS_TABLE_BITS - 2);
  localparam int CW  = ((INDEX_BITS > 16) ? INDEX_BITS : 16) + 1;

  // payload carried down the pipe
  typedef struct packed {
    mode_t              mode;
    logic               rnd;
    logic               neg;
    logic signed [31:0] value;
    logic [15:0]        index;
    logic               last;
  } stage_t;

  // configuration registers
  logic [2:0]         wave_mode;
  logic signed [31:0] amplitude;
  logic [31:0]        phase_step;
  logic [31:0]        phase_start;
  logic [15:0]        decay_factor;
  logic signed [31:0] ramp_step;
  logic signed [31:0] start_value;
  logic [15:0]        sample_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_mode    <= WAVE_MODE_RST;
      amplitude    <= AMPLITUDE_RST;
      phase_step   <= PHASE_STEP_RST;
      phase_start  <= PHASE_START_RST;
      decay_factor <= DECAY_FACTOR_RST;
      ramp_step    <= RAMP_STEP_RST;
      start_value  <= START_VALUE_RST;
      sample_count <= SAMPLE_COUNT_RST;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_WAVE_MODE:    wave_mode    <= cfg_data[2:0];
        REG_AMPLITUDE:    amplitude    <= cfg_data;
        REG_PHASE_STEP:   phase_step   <= cfg_data;
        REG_PHASE_START:  phase_start  <= cfg_data;
        REG_DECAY_FACTOR: decay_factor <= cfg_data[15:0];
        REG_RAMP_STEP:    ramp_step    <= cfg_data;
        REG_START_VALUE:  start_value  <= cfg_data;
        REG_SAMPLE_COUNT: sample_count <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic   v1, v2;
  logic   s1_load, s2_load, out_load;
  stage_t s1, s2;
  logic signed [49:0] prod2;

  assign out_load = v2 && (!out_valid || out_ready);
  assign s2_load  = v1 && (!v2 || out_load);
  assign in_ready = !v1 || !v2 || out_load;
  assign s1_load  = in_valid && in_ready;

  // sequence state
  logic [INDEX_BITS-1:0] index_count;
  logic [31:0]           phase_acc;
  logic signed [31:0]    running_value;

  logic [INDEX_BITS-1:0] idx_eff;
  logic [31:0]           phase_eff;
  logic signed [31:0]    run_eff;
  logic [CW-1:0]         idx_ext, cnt_raw, cnt_min, cnt_eff;
  logic [CW-1:0]         cap;
  logic                  last0;
  mode_t                 mode0;
  logic signed [48:0]    decay_prod;
  logic signed [32:0]    ramp_sum;
  logic signed [31:0]    run_upd;
  logic [INDEX_BITS-1:0] idx_next;
  logic [31:0]           phase_next;
  logic signed [31:0]    running_next;

  assign mode0     = mode_t'(wave_mode[1:0]);
  // a restart beat rewinds before its own sample
  assign idx_eff   = restart ? '0 : index_count;
  assign phase_eff = restart ? phase_start : phase_acc;
  assign run_eff   = restart ? start_value : running_value;

  // effective count: zero acts as one, capped at the index range
  assign cap     = CW'(1) << INDEX_BITS;
  assign cnt_raw = CW'(sample_count);
  assign cnt_min = (cnt_raw == '0) ? CW'(1) : cnt_raw;
  assign cnt_eff = (cnt_min > cap) ? cap : cnt_min;
  assign idx_ext = CW'(idx_eff);
  assign last0   = (idx_ext + CW'(1)) >= cnt_eff;

  assign decay_prod = run_eff * $signed({1'b0, decay_factor});
  assign ramp_sum   = {run_eff[31], run_eff} + {ramp_step[31], ramp_step};

  always_comb begin
    case (mode0)
      MODE_EXP:  run_upd = decay_prod[47:16];
      MODE_RAMP: begin
        if (ramp_sum[32] != ramp_sum[31]) begin
          run_upd = ramp_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
          run_upd = ramp_sum[31:0];
        end
      end
      default:   run_upd = run_eff;
    endcase
  end

  always_comb begin
    if (last0) begin
      idx_next     = '0;
      phase_next   = phase_start;
      running_next = start_value;
    end else begin
      idx_next     = INDEX_BITS'(idx_ext + CW'(1));
      phase_next   = phase_eff + phase_step;
      running_next = run_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      index_count   <= '0;
      phase_acc     <= '0;
      running_value <= '0;
    end else if (s1_load) begin
      index_count   <= idx_next;
      phase_acc     <= phase_next;
      running_value <= running_next;
    end
  end

  // fold the phase onto the first quarter wave
  logic [COS_TABLE_BITS-1:0] addr0;
  logic [1:0]                quad0;
  logic [COS_TABLE_BITS-2:0] r0, k0;
  logic [COS_ENTRY_BITS-1:0] entry1;
  stage_t                    st0;

  assign addr0 = phase_eff[31 -: COS_TABLE_BITS];
  assign quad0 = addr0[COS_TABLE_BITS-1 -: 2];
  assign r0    = {1'b0, addr0[COS_TABLE_BITS-3:0]};
  assign k0    = quad0[0] ? ((COS_TABLE_BITS-1)'(QTR) - r0) : r0;

  always_comb begin
    st0.mode  = mode0;
    st0.rnd   = wave_mode[2];
    st0.neg   = (quad0 == 2'd1) || (quad0 == 2'd2);
    st0.value = (mode0 == MODE_CONST) ? start_value : run_eff;
    st0.index = idx_ext[15:0];
    st0.last  = last0;
  end

  mmwg_cos_rom #(
    .COS_TABLE_BITS(COS_TABLE_BITS)
  ) u_cos_rom (
    .clk (clk),
    .en  (s1_load),
    .addr(k0),
    .data(entry1)
  );

  // stage 1 control and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s1_load) begin
      v1 <= 1'b1;
    end else if (s2_load) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1 <= st0;
    end
  end

  // stage 2: amplitude times signed table entry
  logic signed [COS_ENTRY_BITS:0] entry_s;

  assign entry_s = s1.neg ? -$signed({1'b0, entry1}) : $signed({1'b0, entry1});

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (s2_load) begin
      v2 <= 1'b1;
    end else if (out_load) begin
      v2 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2    <= s1;
      prod2 <= 50'(amplitude) * 50'(entry_s);
    end
  end

  // output stage: saturate the cosine, select, optionally round half away from zero
  logic signed [33:0] cos_wide;
  logic signed [31:0] cos_sat;
  logic signed [31:0] sel;
  logic [33:0]        rnd_pos, rnd_mag;
  logic signed [31:0] rounded;
  logic signed [31:0] sample_next;

  assign cos_wide = prod2[49:16];

  always_comb begin
    if (cos_wide > 34'sh0_7FFF_FFFF) begin
      cos_sat = 32'sh7FFF_FFFF;
    end else if (cos_wide < -34'sh0_8000_0000) begin
      cos_sat = 32'sh8000_0000;
    end else begin
      cos_sat = cos_wide[31:0];
    end
  end

  assign sel = (s2.mode == MODE_COS) ? cos_sat : s2.value;

  always_comb begin
    rnd_pos = '0;
    rnd_mag = '0;
    if (!sel[31]) begin
      rnd_pos = ({2'b00, sel} + ROUND_HALF) & ROUND_MASK;
      if (rnd_pos > ROUND_CAP) begin
        rnd_pos = ROUND_CAP;
      end
      rounded = rnd_pos[31:0];
    end else begin
      rnd_mag = ((-{{2{sel[31]}}, sel}) + ROUND_HALF) & ROUND_MASK;
      rounded = 32'(-rnd_mag);
    end
  end

  assign sample_next = s2.rnd ? rounded : sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample       <= sample_next;
      sample_index <= s2.index;
      last         <= s2.last;
    end
  end

`ifndef SYNTHESIS
  // a last sample rewinds the sequence
  a_wrap_rewinds: assert property (@(posedge clk) disable iff (rst)
    s1_load && last0 |=> index_count == '0)
    else $error("sequence did not rewind after last sample");

  // otherwise the index steps by one
  a_index_steps: assert property (@(posedge clk) disable iff (rst)
    s1_load && !last0 |=> CW'(index_count) == $past(idx_ext) + CW'(1))
    else $error("index did not advance by one");

  // a full stalled pipe takes no new beat
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    v1 && v2 && out_valid && !out_ready |-> !in_ready)
    else $error("input accepted into a full pipe");

  // stage 2 holds its product while the output is stalled
  a_stage2_hold: assert property (@(posedge clk) disable iff (rst)
    v2 && out_valid && !out_ready |=> v2 && $stable(prod2))
    else $error("stage 2 lost its product under stall");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !v1 && !v2)
    else $error("pipe not empty after reset");
`endif

endmodule

`default_nettype wire

[rtl/mmwg_cos_rom.sv]
`default_nettype none

module mmwg_cos_rom
  import mmwg_pkg::*;
#(
  parameter int COS_TABLE_BITS = COS_TABLE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [COS_TABLE_BITS-2:0]    addr,
  output logic      [COS_ENTRY_BITS-1:0]    data
);

  localparam int QTR   = 1 << (COS_TABLE_BITS - 2);
  localparam int DEPTH = QTR + 1;

  typedef logic [COS_ENTRY_BITS-1:0] rom_t [DEPTH];

  // quarter wave cosine by a short taylor-horner chain in q2.30
  function automatic logic [COS_ENTRY_BITS-1:0] quarter_cos(input int k);
    longint unsigned x;
    longint unsigned x2;
    longint t;
    longint e;
    x  = (longint'(k) * TWO_PI_Q30) >> COS_TABLE_BITS;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - longint'((x2 * longint'(t)) >> 30) / 132;
    if (t < 0) t = 0;
    t  = Q30_ONE - longint'((x2 * longint'(t)) >> 30) / 90;
    if (t < 0) t = 0;
    t  = Q30_ONE - longint'((x2 * longint'(t)) >> 30) / 56;
    if (t < 0) t = 0;
    t  = Q30_ONE - longint'((x2 * longint'(t)) >> 30) / 30;
    if (t < 0) t = 0;
    t  = Q30_ONE - longint'((x2 * longint'(t)) >> 30) / 12;
    if (t < 0) t = 0;
    t  = Q30_ONE - longint'((x2 * longint'(t)) >> 30) / 2;
    if (t < 0) t = 0;
    e  = (t + 8192) >>> 14;
    if (e > 65536) e = 65536;
    return COS_ENTRY_BITS'(e);
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < DEPTH; k++) begin
      r[k] = quarter_cos(k);
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  always_ff @(posedge clk) begin
    if (en) begin
      data <= ROM[addr];
    end
  end

endmodule

`default_nettype wire

[sim/tb.sv]
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mmwg_pkg::*;

  typedef longint unsigned u64_t;

  // one expected output beat
  typedef struct packed {
    logic [31:0] value;
    logic [15:0] pos;
    logic        fin;
  } tick_result_t;

  localparam int   TBL_BITS    = COS_TABLE_BITS_DEF;
  localparam u64_t TURN_Q30    = 64'd6746518852;   // 2*pi in q3.30
  localparam longint ONE_Q30   = 64'sd1073741824;
  localparam int   QUIET_LIMIT = 1000;             // cycles with no beat on either side
  localparam int   RANDOM_TICKS = 1200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  reg_index_t  cfg_index = REG_WAVE_MODE;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        restart = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [31:0] sample;
  logic [15:0] sample_index;
  logic        last;

  // model of the generator: register copies and sequence state
  logic [2:0]         r_mode;
  logic signed [31:0] r_amp;
  logic [31:0]        r_pstep;
  logic [31:0]        r_pstart;
  logic [15:0]        r_decay;
  logic signed [31:0] r_rstep;
  logic signed [31:0] r_start;
  logic [15:0]        r_count;
  logic [15:0]        seq_index;
  logic [31:0]        seq_phase;
  logic signed [31:0] seq_level;

  tick_result_t expected_q[$];
  int  errors = 0;
  int  quiet_cycles = 0;
  bit  send_idle = 1'b1;
  bit  recv_idle = 1'b1;
  int  hold_asked = 0;        // bumped by a test to ask for a long receiver hold-off
  int  hold_len = 80;

  always #5 clk = ~clk;

  multi_mode_waveform_generator_top uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .restart      (restart),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample       (sample),
    .sample_index (sample_index),
    .last         (last)
  );

  // ---------------------------------------------------------------------------
  // arithmetic of the generator
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // first quarter of the cosine table, taylor series evaluated horner style
  function automatic longint cos_quarter(int unsigned k);
    u64_t   x;
    u64_t   x2;
    longint t;
    longint d;
    longint e;
    int     i;
    x  = (u64_t'(k) * TURN_Q30) >> TBL_BITS;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    for (i = 0; i < 6; i++) begin
      case (i)
        0: d = 132;
        1: d = 90;
        2: d = 56;
        3: d = 30;
        4: d = 12;
        default: d = 2;
      endcase
      t = ONE_Q30 - longint'((x2 * u64_t'(t)) >> 30) / d;
      if (t < 0) t = 0;
    end
    e = (t + 8192) >>> 14;
    if (e > 65536) e = 65536;
    return e;
  endfunction

  // full table entry with the quadrant folded onto the first quarter
  function automatic longint cos_lookup(logic [31:0] ph);
    int unsigned addr;
    int unsigned quarter;
    int unsigned r;
    addr    = ph >> (32 - TBL_BITS);
    quarter = 1 << (TBL_BITS - 2);
    r       = addr & (quarter - 1);
    case ((addr >> (TBL_BITS - 2)) & 3)
      0:       return cos_quarter(r);
      1:       return -cos_quarter(quarter - r);
      2:       return -cos_quarter(r);
      default: return cos_quarter(quarter - r);
    endcase
  endfunction

  // nearest integer, half away from zero, positive overflow capped at 32767.0
  function automatic logic [31:0] round_near(logic signed [31:0] v);
    longint a;
    a = v;
    if (a >= 0) begin
      a = (a + 32768) & ~longint'(65535);
      if (a > 64'sh7FFF_0000) a = 64'sh7FFF_0000;
    end else begin
      a = -((-a + 32768) & ~longint'(65535));
    end
    return a[31:0];
  endfunction

  task automatic rewind_sequence();
    seq_index = '0;
    seq_phase = r_pstart;
    seq_level = r_start;
  endtask

  task automatic load_reg(reg_index_t idx, logic [31:0] v);
    case (idx)
      REG_WAVE_MODE:    r_mode   = v[2:0];
      REG_AMPLITUDE:    r_amp    = v;
      REG_PHASE_STEP:   r_pstep  = v;
      REG_PHASE_START:  r_pstart = v;
      REG_DECAY_FACTOR: r_decay  = v[15:0];
      REG_RAMP_STEP:    r_rstep  = v;
      REG_START_VALUE:  r_start  = v;
      default:          r_count  = v[15:0];
    endcase
  endtask

  // next sample for one accepted tick beat, queued as the expected output
  task automatic predict_tick(logic rs);
    longint       count;
    logic [31:0]  s;
    tick_result_t want;
    count = (r_count == 16'd0) ? 1 : longint'(r_count);
    if (rs) rewind_sequence();
    case (mode_t'(r_mode[1:0]))
      MODE_CONST: s = r_start;
      MODE_COS:   s = sat32((longint'(r_amp) * cos_lookup(seq_phase)) >>> 16);
      default:    s = seq_level;
    endcase
    if (r_mode[2]) s = round_near(s);
    want.value = s;
    want.pos   = seq_index;
    want.fin   = (longint'(seq_index) + 1) >= count;
    expected_q.push_back(want);
    if (want.fin) begin
      rewind_sequence();
    end else begin
      seq_index = seq_index + 16'd1;
      seq_phase = seq_phase + r_pstep;
      if (mode_t'(r_mode[1:0]) == MODE_EXP)
        seq_level = sat32((longint'(seq_level) * longint'(r_decay)) >>> 16);
      else if (mode_t'(r_mode[1:0]) == MODE_RAMP)
        seq_level = sat32(longint'(seq_level) + longint'(r_rstep));
    end
  endtask

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one tick beat; valid stays up after acceptance so back to back beats
  // can follow without a gap when send_idle is clear, wait_idle drops it
  task automatic send_tick(logic rs);
    int gap;
    gap = send_idle ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    restart  = rs;
    do @(posedge clk); while (!in_ready);
    predict_tick(rs);
  endtask

  // stop offering beats and let every expected sample drain
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write, only called with the pipeline drained
  task automatic write_reg(reg_index_t idx, logic [31:0] v);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    load_reg(idx, v);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // receiver: random stalls per beat, plus a long hold-off when a test asks
  initial begin : drain
    int w;
    int hold_seen;
    hold_seen = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        out_ready = 1'b0;
        repeat (hold_len) @(negedge clk);
      end
      w = recv_idle ? $urandom_range(0, 9) : 0;
      if (w > 0) begin
        out_ready = 1'b0;
        repeat (w) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // compare every output beat with the oldest expected sample
  always @(posedge clk) begin : check_beats
    tick_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        $error("output beat with no sample expected: sample %0d index %0d last %0b",
               sample, sample_index, last);
      end else begin
        want = expected_q.pop_front();
        if (sample !== want.value) begin
          errors++;
          $error("sample: expected %0d, got %0d", $signed(want.value), sample);
        end
        if (sample_index !== want.pos) begin
          errors++;
          $error("sample_index: expected %0d, got %0d", want.pos, sample_index);
        end
        if (last !== want.fin) begin
          errors++;
          $error("last: expected %0b, got %0b", want.fin, last);
        end
      end
    end
  end

  // watchdog on cycles where neither side moves a beat
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // register defaults: constant mode at level zero
  task automatic test_defaults();
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  // constant level, with rounding at both ends and on a negative half
  task automatic test_constant();
    wait_idle();
    write_reg(REG_WAVE_MODE, {29'd0, 1'b1, MODE_CONST});
    write_reg(REG_START_VALUE, 32'h7FFF_8000);   // rounds past the top, capped
    send_tick(1'b0);
    wait_idle();
    write_reg(REG_START_VALUE, 32'h8000_0000);
    send_tick(1'b0);
    wait_idle();
    write_reg(REG_START_VALUE, 32'hFFFF_8000);   // -0.5 goes to -1.0
    send_tick(1'b0);
    wait_idle();
    write_reg(REG_WAVE_MODE, {29'd0, 1'b0, MODE_CONST});
    write_reg(REG_START_VALUE, 32'h0001_8000);
    send_tick(1'b1);
  endtask

  // cosine: quarter turn steps visit every quadrant, most negative amplitude
  // saturates at the negative peak of the table
  task automatic test_cosine();
    wait_idle();
    write_reg(REG_WAVE_MODE, {29'd0, 1'b0, MODE_COS});
    write_reg(REG_AMPLITUDE, 32'h8000_0000);
    write_reg(REG_PHASE_STEP, 32'h4000_0000);
    write_reg(REG_PHASE_START, 32'h0000_0000);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    wait_idle();
    write_reg(REG_WAVE_MODE, {29'd0, 1'b1, MODE_COS});
    write_reg(REG_AMPLITUDE, 32'h7FFF_FFFF);
    write_reg(REG_PHASE_STEP, 32'h0F0F_0F0F);
    write_reg(REG_PHASE_START, 32'hFFFF_FFFF);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  // exponential: slowest decay from the most negative value, then full decay
  task automatic test_exponential();
    wait_idle();
    write_reg(REG_WAVE_MODE, {29'd0, 1'b0, MODE_EXP});
    write_reg(REG_START_VALUE, 32'h8000_0000);
    write_reg(REG_DECAY_FACTOR, 32'h0000_FFFF);
    send_tick(1'b1);
    send_tick(1'b0);
    wait_idle();
    write_reg(REG_START_VALUE, 32'h7FFF_FFFF);
    write_reg(REG_DECAY_FACTOR, 32'h0000_0000);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  // ramp saturating upward, then downward with rounding on
  task automatic test_ramp();
    wait_idle();
    write_reg(REG_WAVE_MODE, {29'd0, 1'b0, MODE_RAMP});
    write_reg(REG_START_VALUE, 32'h7FFF_0000);
    write_reg(REG_RAMP_STEP, 32'h7FFF_FFFF);
    send_tick(1'b1);
    send_tick(1'b0);
    wait_idle();
    write_reg(REG_WAVE_MODE, {29'd0, 1'b1, MODE_RAMP});
    write_reg(REG_START_VALUE, 32'h8000_0000);
    write_reg(REG_RAMP_STEP, 32'h8000_0000);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  // sample count of zero acts as one; lowering the count below the running
  // index ends the sequence at once
  task automatic test_count_edges();
    wait_idle();
    write_reg(REG_SAMPLE_COUNT, 32'h0000_0000);
    send_tick(1'b0);
    send_tick(1'b0);
    wait_idle();
    write_reg(REG_SAMPLE_COUNT, 32'h0000_FFFF);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    wait_idle();
    write_reg(REG_SAMPLE_COUNT, 32'h0000_0002);
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  // every register drawn at random, extremes mixed in
  task automatic random_setting();
    logic [15:0] v16;
    wait_idle();
    write_reg(REG_WAVE_MODE, {29'($urandom), 3'($urandom_range(0, 7))});
    write_reg(REG_AMPLITUDE, pick_word());
    write_reg(REG_PHASE_STEP, pick_word());
    write_reg(REG_PHASE_START, pick_word());
    case ($urandom_range(0, 4))
      0:       v16 = 16'd0;
      1:       v16 = 16'hFFFF;
      2:       v16 = 16'($urandom_range(60000, 65535));
      default: v16 = 16'($urandom);
    endcase
    write_reg(REG_DECAY_FACTOR, {16'($urandom), v16});
    write_reg(REG_RAMP_STEP, pick_word());
    write_reg(REG_START_VALUE, pick_word());
    case ($urandom_range(0, 9))
      0:       v16 = 16'd0;
      1:       v16 = 16'hFFFF;
      2, 3:    v16 = 16'($urandom_range(41, 400));
      default: v16 = 16'($urandom_range(1, 40));
    endcase
    write_reg(REG_SAMPLE_COUNT, {16'($urandom), v16});
  endtask

  task automatic test_random();
    int done;
    int n;
    int i;
    done = 0;
    while (done < RANDOM_TICKS) begin
      random_setting();
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      n = $urandom_range(20, 100);
      for (i = 0; i < n; i++) begin
        send_tick(i == 0 ? 1'($urandom) : ($urandom_range(0, 15) == 0));
      end
      done += n;
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  // receiver stops for a long stretch while ticks keep coming, so the
  // pipeline fills and in_ready has to drop
  task automatic test_backpressure();
    int i;
    wait_idle();
    write_reg(REG_WAVE_MODE, {29'd0, 1'b0, MODE_RAMP});
    write_reg(REG_START_VALUE, 32'hFFF0_0000);
    write_reg(REG_RAMP_STEP, 32'h0000_8001);
    write_reg(REG_SAMPLE_COUNT, 32'd17);
    send_idle = 1'b0;
    hold_asked = hold_asked + 1;
    for (i = 0; i < 30; i++) send_tick(i == 0);
    send_idle = 1'b1;
  endtask

  initial begin
    r_mode   = WAVE_MODE_RST;
    r_amp    = AMPLITUDE_RST;
    r_pstep  = PHASE_STEP_RST;
    r_pstart = PHASE_START_RST;
    r_decay  = DECAY_FACTOR_RST;
    r_rstep  = RAMP_STEP_RST;
    r_start  = START_VALUE_RST;
    r_count  = SAMPLE_COUNT_RST;
    rewind_sequence();

    repeat (7) @(negedge clk);
    rst = 1'b0;

    test_defaults();
    test_constant();
    test_cosine();
    test_exponential();
    test_ramp();
    test_count_edges();
    test_backpressure();
    test_random();
    test_backpressure();

    wait_idle();
    repeat (20) @(posedge clk);
    if (expected_q.size() != 0)
      $error("%0d expected samples never came out", expected_q.size());
    if (errors == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

[multi_mode_waveform_generator_top.f]
rtl/mmwg_pkg.sv
rtl/mmwg_cos_rom.sv
rtl/multi_mode_waveform_generator_top.sv
sim/tb.sv
